[sv/rne_pkg.sv]
// types, constants and digit helpers shared by the roman numeral encoder
package rne_pkg;

  localparam int VALUE_W    = 16;
  localparam int LIMIT_W    = 12;
  localparam int LETTER_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int DIGIT_W    = 4;
  localparam int POS_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [VALUE_W-1:0]  ROMAN_MAX   = VALUE_W'(3999);
  localparam logic [LIMIT_W-1:0]  LOWER_RESET = LIMIT_W'(1000);
  localparam logic [LIMIT_W-1:0]  UPPER_RESET = LIMIT_W'(2999);

  localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(1);

  localparam logic [1:0] POS_THOUSANDS = 2'd0;
  localparam logic [1:0] POS_HUNDREDS  = 2'd1;
  localparam logic [1:0] POS_TENS      = 2'd2;
  localparam logic [1:0] POS_ONES      = 2'd3;

  localparam logic [LETTER_W-1:0] CHAR_NONE = 7'h00;
  localparam logic [LETTER_W-1:0] CHAR_I    = 7'h49;
  localparam logic [LETTER_W-1:0] CHAR_V    = 7'h56;
  localparam logic [LETTER_W-1:0] CHAR_X    = 7'h58;
  localparam logic [LETTER_W-1:0] CHAR_L    = 7'h4C;
  localparam logic [LETTER_W-1:0] CHAR_C    = 7'h43;
  localparam logic [LETTER_W-1:0] CHAR_D    = 7'h44;
  localparam logic [LETTER_W-1:0] CHAR_M    = 7'h4D;

  typedef struct packed {
    logic               err;
    logic               zero;
    logic [1:0]         th;
    logic [DIGIT_W-1:0] hu;
    logic [DIGIT_W-1:0] te;
    logic [DIGIT_W-1:0] on;
    logic [1:0]         first;
  } item_t;

  function automatic logic [DIGIT_W-1:0] hundreds_digit(input logic [9:0] x);
    logic [DIGIT_W-1:0] q;
    q = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 10'(k * 100)) q = DIGIT_W'(k);
    end
    return q;
  endfunction

  function automatic logic [6:0] hundreds_rem(input logic [9:0] x);
    logic [9:0] r;
    r = x;
    for (int k = 1; k < 10; k++) begin
      if (x >= 10'(k * 100)) r = x - 10'(k * 100);
    end
    return r[6:0];
  endfunction

  function automatic logic [DIGIT_W-1:0] tens_digit(input logic [6:0] x);
    logic [DIGIT_W-1:0] q;
    q = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 7'(k * 10)) q = DIGIT_W'(k);
    end
    return q;
  endfunction

  function automatic logic [DIGIT_W-1:0] tens_rem(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    for (int k = 1; k < 10; k++) begin
      if (x >= 7'(k * 10)) r = x - 7'(k * 10);
    end
    return r[DIGIT_W-1:0];
  endfunction

  // number of letters a decimal digit turns into
  function automatic logic [POS_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
    logic [POS_W-1:0] n;
    case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [LETTER_W-1:0] letter_of(input logic [1:0] place,
                                                    input logic [DIGIT_W-1:0] d,
                                                    input logic [POS_W-1:0] p);
    logic [LETTER_W-1:0] one;
    logic [LETTER_W-1:0] five;
    logic [LETTER_W-1:0] ten;
    logic [LETTER_W-1:0] c;
    case (place)
      POS_THOUSANDS: begin one = CHAR_M; five = CHAR_M; ten = CHAR_M; end
      POS_HUNDREDS:  begin one = CHAR_C; five = CHAR_D; ten = CHAR_M; end
      POS_TENS:      begin one = CHAR_X; five = CHAR_L; ten = CHAR_C; end
      POS_ONES:      begin one = CHAR_I; five = CHAR_V; ten = CHAR_X; end
      default:       begin one = CHAR_I; five = CHAR_V; ten = CHAR_X; end
    endcase
    if (d == 4'd9) begin
      c = (p == '0) ? one : ten;
    end else if (d == 4'd4) begin
      c = (p == '0) ? one : five;
    end else if (d >= 4'd5) begin
      c = (p == '0) ? five : one;
    end else begin
      c = one;
    end
    return c;
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_at(input item_t it, input logic [1:0] place);
    logic [DIGIT_W-1:0] d;
    case (place)
      POS_THOUSANDS: d = {2'b00, it.th};
      POS_HUNDREDS:  d = it.hu;
      POS_TENS:      d = it.te;
      POS_ONES:      d = it.on;
      default:       d = it.on;
    endcase
    return d;
  endfunction

  // {found, place} of the first nonzero digit after place cur
  function automatic logic [2:0] next_digit(input logic [3:0] nz, input logic [1:0] cur);
    logic [2:0] res;
    res = '0;
    for (int i = 3; i >= 0; i--) begin
      if (nz[i] && (2'(i) > cur)) res = {1'b1, 2'(i)};
    end
    return res;
  endfunction

endpackage

[sv/roman_numeral_encoder_core.sv]
// top level of the roman numeral encoder
//
//   channel  handshake               payload
//   in       in_valid / in_ready     value[15:0]
//   out      out_valid / out_ready   letter[6:0], last, range_error
//   cfg      cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[11:0]
//
// one letter leaves per cycle while out_ready is high; a request yields 1 to 15 letters
// first letter shows after the request passes first split stage, second split stage, queue, output reg
// a four-entry queue lets intake run ahead while the letter walker drains a long numeral
// rst is synchronous; limits return to 1000 and 2999, queue and output are emptied
// cfg_ready is always high; limits take effect on the next request
module roman_numeral_encoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rne_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rne_pkg::LETTER_W-1:0]  letter,
  output logic                          last,
  output logic                          range_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rne_pkg::LIMIT_W-1:0]   cfg_data
);
  import rne_pkg::*;

  logic [LIMIT_W-1:0] lower_limit;
  logic [LIMIT_W-1:0] upper_limit;

  logic  push;
  item_t push_data;
  logic  full;
  logic  pop;
  logic  not_empty;
  item_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit <= LOWER_RESET;
      upper_limit <= UPPER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LOWER) lower_limit <= cfg_data;
      if (cfg_index == REG_UPPER) upper_limit <= cfg_data;
    end
  end

  rne_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .lower_limit (lower_limit),
    .upper_limit (upper_limit),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  rne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  rne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .letter      (letter),
    .last        (last),
    .range_error (range_error)
  );

endmodule

[sv/rne_front.sv]
// front end: request intake, window check and decimal digit split
module rne_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rne_pkg::VALUE_W-1:0] value,
  input  logic [rne_pkg::LIMIT_W-1:0] lower_limit,
  input  logic [rne_pkg::LIMIT_W-1:0] upper_limit,
  output logic                        push,
  output rne_pkg::item_t              push_data,
  input  logic                        full
);
  import rne_pkg::*;

  logic              s1_valid;
  logic              s1_err;
  logic [1:0]        s1_th;
  logic [9:0]        s1_rem;
  logic              s2_valid;
  logic              s2_err;
  logic [1:0]        s2_th;
  logic [DIGIT_W-1:0] s2_hu;
  logic [6:0]        s2_rem;

  logic              s1_adv;
  logic              s2_ready;
  logic              in_err;
  logic [11:0]       v12;
  logic [1:0]        th_c;
  logic [11:0]       th_base;
  logic [DIGIT_W-1:0] te_c;
  logic [DIGIT_W-1:0] on_c;
  logic [3:0]        nz;
  logic [2:0]        first_c;

  assign push     = s2_valid && !full;
  assign s2_ready = !s2_valid || push;
  assign s1_adv   = s1_valid && s2_ready;
  assign in_ready = !s1_valid || s1_adv;

  assign v12    = value[11:0];
  assign in_err = (value > ROMAN_MAX) ||
                  (value < {{(VALUE_W-LIMIT_W){1'b0}}, lower_limit}) ||
                  (value > {{(VALUE_W-LIMIT_W){1'b0}}, upper_limit});

  always_comb begin
    if (v12 >= 12'd3000) begin
      th_c = 2'd3; th_base = 12'd3000;
    end else if (v12 >= 12'd2000) begin
      th_c = 2'd2; th_base = 12'd2000;
    end else if (v12 >= 12'd1000) begin
      th_c = 2'd1; th_base = 12'd1000;
    end else begin
      th_c = 2'd0; th_base = 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_err <= in_err;
      s1_th  <= th_c;
      s1_rem <= 10'(v12 - th_base);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (push) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_err <= s1_err;
      s2_th  <= s1_th;
      s2_hu  <= hundreds_digit(s1_rem);
      s2_rem <= hundreds_rem(s1_rem);
    end
  end

  assign te_c    = tens_digit(s2_rem);
  assign on_c    = tens_rem(s2_rem);
  assign nz      = {on_c != '0, te_c != '0, s2_hu != '0, s2_th != '0};
  assign first_c = next_digit({nz[3:1], 1'b0}, POS_THOUSANDS);

  always_comb begin
    push_data.err   = s2_err;
    push_data.zero  = !s2_err && (nz == '0);
    push_data.th    = s2_th;
    push_data.hu    = s2_hu;
    push_data.te    = te_c;
    push_data.on    = on_c;
    push_data.first = nz[0] ? POS_THOUSANDS : first_c[1:0];
  end

endmodule

[sv/rne_queue.sv]
// small register queue between the front and back ends
module rne_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rne_pkg::item_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rne_pkg::item_t head
);
  import rne_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

[sv/rne_back.sv]
// back end: walks the queued digits and sends one letter per cycle while the output is not stalled
module rne_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         not_empty,
  input  rne_pkg::item_t               head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rne_pkg::LETTER_W-1:0] letter,
  output logic                         last,
  output logic                         range_error
);
  import rne_pkg::*;

  logic               started;
  logic [1:0]         di;
  logic [POS_W-1:0]   pos;

  logic               emit;
  logic [1:0]         cur_di;
  logic [POS_W-1:0]   cur_pos;
  logic [DIGIT_W-1:0] cur_d;
  logic               more;
  logic [2:0]         nxt;
  logic [3:0]         nz;
  logic               last_c;
  logic [LETTER_W-1:0] letter_c;

  assign emit    = not_empty && (!out_valid || out_ready);
  assign cur_di  = started ? di : head.first;
  assign cur_pos = started ? pos : '0;
  assign cur_d   = digit_at(head, cur_di);
  assign more    = (cur_pos + 1'b1) < digit_len(cur_d);
  assign nz      = {head.on != '0, head.te != '0, head.hu != '0, head.th != '0};
  assign nxt     = next_digit(nz, cur_di);
  assign last_c  = head.err || head.zero || (!more && !nxt[2]);
  assign pop     = emit && last_c;

  always_comb begin
    if (head.err || head.zero) begin
      letter_c = CHAR_NONE;
    end else begin
      letter_c = letter_of(cur_di, cur_d, cur_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      started   <= !last_c;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      letter      <= letter_c;
      last        <= last_c;
      range_error <= head.err;
      di          <= more ? cur_di : nxt[1:0];
      pos         <= more ? cur_pos + 1'b1 : '0;
    end
  end

endmodule

[sv/rne_checker.sv]
// port-level checks for the roman numeral encoder, bound to the top level
module rne_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rne_pkg::LETTER_W-1:0]  letter,
  input logic                          last,
  input logic                          range_error
);
  import rne_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(letter) && $stable(last) &&
    $stable(range_error))
    else $error("stalled result changed");

  // error result is a single empty letter
  assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last && (letter == CHAR_NONE))
    else $error("error result malformed");

  // an empty letter without error only for zero, which is a single result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error && (letter == CHAR_NONE) |-> last)
    else $error("zero result not flagged last");

  // letters are roman digits only
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (letter != CHAR_NONE) |->
    (letter == CHAR_I) || (letter == CHAR_V) || (letter == CHAR_X) ||
    (letter == CHAR_L) || (letter == CHAR_C) || (letter == CHAR_D) ||
    (letter == CHAR_M))
    else $error("letter outside roman set");

endmodule

bind roman_numeral_encoder_core rne_checker u_rne_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .letter      (letter),
  .last        (last),
  .range_error (range_error)
);
